FILE: src/vectored_interrupt_controller_core_defines.svh
// assertion macros for the vectored interrupt controller checker
`ifndef VECTORED_INTERRUPT_CONTROLLER_CORE_DEFINES_SVH
`define VECTORED_INTERRUPT_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication
`define VIC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vic check failed");

// next-cycle implication
`define VIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vic check failed");

`endif

FILE: src/vic_pkg.sv
// shared codes, register map and types of the vectored interrupt controller
package vic_pkg;

	localparam int DefNumSlots   = 16;
	localparam int DefNumSources = 32;

	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_LINE  = 2'd2;

	localparam logic [1:0] SZ_BYTE = 2'd0;
	localparam logic [1:0] SZ_HALF = 2'd1;
	localparam logic [1:0] SZ_WORD = 2'd2;
	localparam logic [1:0] SZ_BAD  = 2'd3;

	// word offsets
	localparam logic [7:0] REG_IRQ_STATUS = 8'h00;
	localparam logic [7:0] REG_FIQ_STATUS = 8'h01;
	localparam logic [7:0] REG_RAW        = 8'h02;
	localparam logic [7:0] REG_SELECT     = 8'h03;
	localparam logic [7:0] REG_EN_SET     = 8'h04;
	localparam logic [7:0] REG_EN_CLR     = 8'h05;
	localparam logic [7:0] REG_SOFT_SET   = 8'h06;
	localparam logic [7:0] REG_SOFT_CLR   = 8'h07;
	localparam logic [7:0] REG_VECT       = 8'h0C;
	localparam logic [7:0] REG_DEFV       = 8'h0D;
	localparam logic [7:0] VEC_BASE_W     = 8'h40;
	localparam logic [7:0] CTL_BASE_W     = 8'h80;

	localparam int CtrlEnableBit = 5;
	localparam int CtrlSrcMsb    = 4;

	typedef struct packed {
		logic        vec_we;
		logic        ctl_we;
		logic [31:0] data;
	} vic_store_wr_t;

endpackage

FILE: src/vic_slot_store.sv
// vector address and slot control storage with one shared address port
module vic_slot_store #(
	parameter int NUM_SLOTS = vic_pkg::DefNumSlots,
	parameter int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  vic_pkg::vic_store_wr_t wr,
	input  logic [SLOT_W-1:0]     addr,
	output logic [31:0]           vec_rdata,
	output logic [7:0]            ctl_rdata
);
	import vic_pkg::*;

	logic [31:0] vec_q [NUM_SLOTS];
	logic [7:0]  ctl_q [NUM_SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				vec_q[i] <= '0;
				ctl_q[i] <= '0;
			end
		end else begin
			if (wr.vec_we) begin
				vec_q[addr] <= wr.data;
			end
			if (wr.ctl_we) begin
				ctl_q[addr] <= wr.data[7:0];
			end
		end
	end

	assign vec_rdata = vec_q[addr];
	assign ctl_rdata = ctl_q[addr];

endmodule

FILE: src/vic_slot_match.sv
// compare unit: does a slot control byte select a pending irq source
module vic_slot_match (
	input  logic [7:0]  ctl,
	input  logic [31:0] irqs,
	output logic        hit
);
	import vic_pkg::*;

	assign hit = ctl[CtrlEnableBit] && irqs[ctl[CtrlSrcMsb:0]];

endmodule

FILE: src/vectored_interrupt_controller_core.sv
// vectored interrupt controller core: register file, bus decode and slot scan sequencer
// a beat that leaves the irq state alone passes EXEC only, one that re-evaluates
// the lines also passes PREP, and when the slot scan runs SCAN visits up to NUM_SLOTS
// slots (one slot per cycle through the shared compare unit), one beat at a time
// a new beat is taken the cycle after the result beat leaves
// reset clears every register, the vector table and the slot controls
module vectored_interrupt_controller_core #(
	parameter int NUM_SLOTS   = vic_pkg::DefNumSlots,
	parameter int NUM_SOURCES = vic_pkg::DefNumSources
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  req_type,
	input  logic [9:0]  byte_offset,
	input  logic [1:0]  access_size,
	input  logic [31:0] write_data,
	input  logic [4:0]  source_number,
	input  logic        source_level,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [31:0] read_data,
	output logic        bus_error,
	output logic        fiq_line,
	output logic        irq_line
);
	import vic_pkg::*;

	localparam int SlotW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int VecEnd = 'h40 + NUM_SLOTS;
	localparam int CtlEnd = 'h80 + NUM_SLOTS;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_PREP = 2'd2;
	localparam logic [1:0] ST_SCAN = 2'd3;

	logic [1:0]  state_q;
	logic [1:0]  req_type_q;
	logic [9:0]  byte_offset_q;
	logic [1:0]  access_size_q;
	logic [31:0] write_data_q;
	logic [4:0]  source_number_q;
	logic        source_level_q;

	logic [31:0] raw_q, soft_q, sel_q, en_q, cur_vec_q, def_vec_q, irqs_q;
	logic        in_service_q, fiq_q;
	logic [SlotW-1:0] scan_idx_q;
	logic        rsp_valid_q, bus_error_q;
	logic [31:0] read_data_q;

	logic        accept;
	logic [7:0]  w, vec_off, ctl_off;
	logic        in_vec, in_ctl, is_wr;
	logic [31:0] mask, dm, rdv;
	logic        err, rc, line_upd, ack;
	logic        wr_sel, wr_en_set, wr_en_clr, wr_soft_set, wr_soft_clr, wr_defv;
	vic_store_wr_t st_wr, st_wr_g;
	logic [SlotW-1:0] bus_idx, st_addr;
	logic [31:0] vec_rdata;
	logic [7:0]  ctl_rdata;
	logic        hit;
	logic [31:0] act, fiqs, irqs;
	logic        last_slot;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE) || rsp_valid_q;

	assign act  = (raw_q | soft_q) & en_q;
	assign fiqs = act & sel_q;
	assign irqs = act & ~sel_q;

	assign w       = byte_offset_q[9:2];
	assign vec_off = w - VEC_BASE_W;
	assign ctl_off = w - CTL_BASE_W;
	assign in_vec  = (w >= VEC_BASE_W) && ({1'b0, w} < 9'(VecEnd));
	assign in_ctl  = (w >= CTL_BASE_W) && ({1'b0, w} < 9'(CtlEnd));
	assign bus_idx = in_ctl ? ctl_off[SlotW-1:0] : vec_off[SlotW-1:0];
	assign is_wr   = (req_type_q == REQ_WRITE);
	assign dm      = write_data_q & mask;

	always_comb begin
		unique case (access_size_q)
			SZ_BYTE: mask = 32'h0000_00FF;
			SZ_HALF: mask = 32'h0000_FFFF;
			SZ_WORD: mask = 32'hFFFF_FFFF;
			SZ_BAD:  mask = 32'h0000_0000;
		endcase
	end

	always_comb begin
		err = 1'b0;
		rc = 1'b0;
		line_upd = 1'b0;
		ack = 1'b0;
		rdv = '0;
		wr_sel = 1'b0;
		wr_en_set = 1'b0;
		wr_en_clr = 1'b0;
		wr_soft_set = 1'b0;
		wr_soft_clr = 1'b0;
		wr_defv = 1'b0;
		st_wr = '{vec_we: 1'b0, ctl_we: 1'b0, data: dm};
		if (req_type_q == REQ_LINE) begin
			if ({1'b0, source_number_q} < 6'(NUM_SOURCES)) begin
				line_upd = 1'b1;
				rc = 1'b1;
			end
		end else if (req_type_q == REQ_READ || req_type_q == REQ_WRITE) begin
			if (byte_offset_q[1:0] != 2'b00 || access_size_q == SZ_BAD) begin
				err = 1'b1;
			end else if (in_vec) begin
				st_wr.vec_we = is_wr;
				rdv = vec_rdata;
			end else if (in_ctl) begin
				st_wr.ctl_we = is_wr;
				rdv = {24'd0, ctl_rdata};
			end else begin
				unique case (w)
					REG_IRQ_STATUS: begin
						err = is_wr;
						rdv = irqs;
					end
					REG_FIQ_STATUS: begin
						err = is_wr;
						rdv = fiqs;
					end
					REG_RAW: begin
						err = is_wr;
						rdv = raw_q | soft_q;
					end
					REG_SELECT: begin
						wr_sel = is_wr;
						rc = is_wr;
						rdv = sel_q;
					end
					REG_EN_SET: begin
						wr_en_set = is_wr;
						rc = is_wr;
						rdv = en_q;
					end
					REG_EN_CLR: begin
						wr_en_clr = is_wr;
						rc = is_wr;
					end
					REG_SOFT_SET: begin
						wr_soft_set = is_wr;
						rc = is_wr;
						rdv = soft_q;
					end
					REG_SOFT_CLR: begin
						wr_soft_clr = is_wr;
						rc = is_wr;
					end
					REG_VECT: begin
						ack = is_wr && in_service_q;
						rc = is_wr && in_service_q;
						rdv = cur_vec_q;
					end
					REG_DEFV: begin
						wr_defv = is_wr;
						rdv = def_vec_q;
					end
					default: err = 1'b1;
				endcase
			end
		end
	end

	assign st_wr_g = (state_q == ST_EXEC) ? st_wr : '0;
	assign st_addr = (state_q == ST_SCAN) ? scan_idx_q : bus_idx;

	vic_slot_store #(
		.NUM_SLOTS (NUM_SLOTS),
		.SLOT_W    (SlotW)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (st_wr_g),
		.addr      (st_addr),
		.vec_rdata (vec_rdata),
		.ctl_rdata (ctl_rdata)
	);

	vic_slot_match u_match (
		.ctl  (ctl_rdata),
		.irqs (irqs_q),
		.hit  (hit)
	);

	assign last_slot = (scan_idx_q == SlotW'(NUM_SLOTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_type_q <= '0;
			byte_offset_q <= '0;
			access_size_q <= '0;
			write_data_q <= '0;
			source_number_q <= '0;
			source_level_q <= 1'b0;
		end else if (accept) begin
			req_type_q <= req_type;
			byte_offset_q <= byte_offset;
			access_size_q <= access_size;
			write_data_q <= write_data;
			source_number_q <= source_number;
			source_level_q <= source_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			raw_q <= '0;
			soft_q <= '0;
			sel_q <= '0;
			en_q <= '0;
			cur_vec_q <= '0;
			def_vec_q <= '0;
			irqs_q <= '0;
			in_service_q <= 1'b0;
			fiq_q <= 1'b0;
			scan_idx_q <= '0;
			rsp_valid_q <= 1'b0;
			bus_error_q <= 1'b0;
			read_data_q <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (line_upd) begin
						raw_q[source_number_q] <= source_level_q;
					end
					if (wr_sel) begin
						sel_q <= dm;
					end
					if (wr_en_set) begin
						en_q <= en_q | dm;
					end
					if (wr_en_clr) begin
						en_q <= en_q & ~dm;
					end
					if (wr_soft_set) begin
						soft_q <= soft_q | dm;
					end
					if (wr_soft_clr) begin
						soft_q <= soft_q & ~dm;
					end
					if (wr_defv) begin
						def_vec_q <= dm;
					end
					if (ack) begin
						in_service_q <= 1'b0;
					end
					bus_error_q <= err;
					read_data_q <= (err || is_wr) ? 32'd0 : (rdv & mask);
					if (rc) begin
						state_q <= ST_PREP;
					end else begin
						rsp_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_PREP: begin
					fiq_q <= (fiqs != 32'd0);
					irqs_q <= irqs;
					scan_idx_q <= '0;
					if (irqs != 32'd0 && !in_service_q) begin
						state_q <= ST_SCAN;
					end else begin
						rsp_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (hit || last_slot) begin
						cur_vec_q <= hit ? vec_rdata : def_vec_q;
						in_service_q <= 1'b1;
						rsp_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						scan_idx_q <= scan_idx_q + SlotW'(1);
					end
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign read_data = read_data_q;
	assign bus_error = bus_error_q;
	assign fiq_line  = fiq_q;
	assign irq_line  = in_service_q;

endmodule

FILE: src/vic_checker.sv
// port-level checks for the vectored interrupt controller core and their binding
`include "vectored_interrupt_controller_core_defines.svh"

module vic_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic [1:0]  req_type,
	input logic [9:0]  byte_offset,
	input logic [1:0]  access_size,
	input logic [31:0] write_data,
	input logic [4:0]  source_number,
	input logic        source_level,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [31:0] read_data,
	input logic        bus_error,
	input logic        fiq_line,
	input logic        irq_line
);

	`VIC_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(read_data) && $stable(bus_error) && $stable(irq_line))
	`VIC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && !req_stall, req_stall)
	`VIC_ASSERT_NOW(a_stall_while_rsp, clk, arst_n, rsp_valid, req_stall)
	`VIC_ASSERT_NOW(a_err_zero_data, clk, arst_n, rsp_valid && bus_error, read_data == 32'd0)

endmodule

bind vectored_interrupt_controller_core vic_checker u_vic_checker (.*);

FILE: test/vic_response_checker.sv
`timescale 1ns / 100ps
// response checker for the vectored interrupt controller: shadow register state and per-beat compare
module vic_response_checker #(
	parameter int NUM_SLOTS   = vic_pkg::DefNumSlots,
	parameter int NUM_SOURCES = vic_pkg::DefNumSources
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  logic [1:0]  req_type,
	input  logic [9:0]  byte_offset,
	input  logic [1:0]  access_size,
	input  logic [31:0] write_data,
	input  logic [4:0]  source_number,
	input  logic        source_level,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  logic [31:0] read_data,
	input  logic        bus_error,
	input  logic        fiq_line,
	input  logic        irq_line,
	output int          mismatches,
	output int          outstanding
);
	import vic_pkg::*;

	typedef struct packed {
		logic [31:0] rdata;
		logic        err;
		logic        fiq;
		logic        irq;
	} vic_outcome_t;

	logic [31:0] line_level;
	logic [31:0] soft_bits;
	logic [31:0] fast_mask;
	logic [31:0] enable_bits;
	logic [31:0] latched_vector;
	logic [31:0] fallback_vector;
	logic [31:0] slot_vector [NUM_SLOTS];
	logic [7:0]  slot_ctrl [NUM_SLOTS];
	logic        irq_held;
	logic        fiq_held;

	vic_outcome_t outcome_q[$];

	initial mismatches = 0;

	function automatic logic [31:0] active_sources();
		return (line_level | soft_bits) & enable_bits;
	endfunction

	// fiq level follows the lines, the irq slot scan only runs with nothing in service
	function automatic void rescan_lines();
		logic [31:0] irqs;
		logic [31:0] pick;
		logic        found;
		irqs = active_sources() & ~fast_mask;
		fiq_held = |(active_sources() & fast_mask);
		if (irqs != 32'd0 && !irq_held) begin
			pick = fallback_vector;
			found = 1'b0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (!found && slot_ctrl[i][CtrlEnableBit] && irqs[slot_ctrl[i][CtrlSrcMsb:0]]) begin
					pick = slot_vector[i];
					found = 1'b1;
				end
			end
			latched_vector = pick;
			irq_held = 1'b1;
		end
	endfunction

	// returns the bus error flag
	function automatic logic access_regs(input logic wr, input logic [9:0] off,
			input logic [1:0] size, input logic [31:0] wdata, output logic [31:0] rdata);
		logic [31:0] mask;
		logic [31:0] val;
		logic [31:0] data;
		logic [7:0]  w;
		rdata = 32'd0;
		val = 32'd0;
		if (off[1:0] != 2'b00)
			return 1'b1;
		case (size)
			SZ_BYTE: mask = 32'h0000_00FF;
			SZ_HALF: mask = 32'h0000_FFFF;
			SZ_WORD: mask = 32'hFFFF_FFFF;
			default: return 1'b1;
		endcase
		data = wdata & mask;
		w = off[9:2];
		if (w >= VEC_BASE_W && w < VEC_BASE_W + NUM_SLOTS) begin
			if (wr)
				slot_vector[w - VEC_BASE_W] = data;
			else
				val = slot_vector[w - VEC_BASE_W];
		end else if (w >= CTL_BASE_W && w < CTL_BASE_W + NUM_SLOTS) begin
			if (wr)
				slot_ctrl[w - CTL_BASE_W] = data[7:0];
			else
				val = {24'd0, slot_ctrl[w - CTL_BASE_W]};
		end else begin
			case (w)
				REG_IRQ_STATUS: begin
					if (wr)
						return 1'b1;
					val = active_sources() & ~fast_mask;
				end
				REG_FIQ_STATUS: begin
					if (wr)
						return 1'b1;
					val = active_sources() & fast_mask;
				end
				REG_RAW: begin
					if (wr)
						return 1'b1;
					val = line_level | soft_bits;
				end
				REG_SELECT: begin
					if (wr) begin
						fast_mask = data;
						rescan_lines();
					end else
						val = fast_mask;
				end
				REG_EN_SET: begin
					if (wr) begin
						enable_bits |= data;
						rescan_lines();
					end else
						val = enable_bits;
				end
				REG_EN_CLR: begin
					if (wr) begin
						enable_bits &= ~data;
						rescan_lines();
					end
				end
				REG_SOFT_SET: begin
					if (wr) begin
						soft_bits |= data;
						rescan_lines();
					end else
						val = soft_bits;
				end
				REG_SOFT_CLR: begin
					if (wr) begin
						soft_bits &= ~data;
						rescan_lines();
					end
				end
				REG_VECT: begin
					if (wr) begin
						if (irq_held) begin
							irq_held = 1'b0;
							rescan_lines();
						end
					end else
						val = latched_vector;
				end
				REG_DEFV: begin
					if (wr)
						fallback_vector = data;
					else
						val = fallback_vector;
				end
				default: return 1'b1;
			endcase
		end
		rdata = wr ? 32'd0 : (val & mask);
		return 1'b0;
	endfunction

	function automatic vic_outcome_t predict_beat(input logic [1:0] kind, input logic [9:0] off,
			input logic [1:0] size, input logic [31:0] wdata, input logic [4:0] src,
			input logic lvl);
		vic_outcome_t o;
		logic [31:0]  rd;
		logic         err;
		rd = 32'd0;
		err = 1'b0;
		if (kind == REQ_READ || kind == REQ_WRITE) begin
			err = access_regs(kind == REQ_WRITE, off, size, wdata, rd);
			if (err)
				rd = 32'd0;
		end else if (kind == REQ_LINE) begin
			if (src < NUM_SOURCES) begin
				line_level[src] = lvl;
				rescan_lines();
			end
		end
		o.rdata = rd;
		o.err = err;
		o.fiq = fiq_held;
		o.irq = irq_held;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		vic_outcome_t want;
		if (!arst_n) begin
			line_level = 32'd0;
			soft_bits = 32'd0;
			fast_mask = 32'd0;
			enable_bits = 32'd0;
			latched_vector = 32'd0;
			fallback_vector = 32'd0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_vector[i] = 32'd0;
				slot_ctrl[i] = 8'd0;
			end
			irq_held = 1'b0;
			fiq_held = 1'b0;
			outcome_q.delete();
			outstanding <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (outcome_q.size() == 0) begin
					mismatches++;
					$display("%0t: result beat with nothing expected, read_data %h", $time,
						read_data);
				end else begin
					want = outcome_q.pop_front();
					if (read_data !== want.rdata) begin
						mismatches++;
						$display("%0t: read_data expected %h actual %h", $time, want.rdata,
							read_data);
					end
					if (bus_error !== want.err) begin
						mismatches++;
						$display("%0t: bus_error expected %b actual %b", $time, want.err,
							bus_error);
					end
					if (fiq_line !== want.fiq) begin
						mismatches++;
						$display("%0t: fiq_line expected %b actual %b", $time, want.fiq,
							fiq_line);
					end
					if (irq_line !== want.irq) begin
						mismatches++;
						$display("%0t: irq_line expected %b actual %b", $time, want.irq,
							irq_line);
					end
				end
			end
			if (req_valid && !req_stall)
				outcome_q.push_back(predict_beat(req_type, byte_offset, access_size, write_data,
					source_number, source_level));
			outstanding <= outcome_q.size();
		end
	end

endmodule

FILE: test/tb_vectored_interrupt_controller_core.sv
`timescale 1ns / 100ps
// testbench top for the vectored interrupt controller core: stimulus, idling and verdict
module tb_vectored_interrupt_controller_core;
	import vic_pkg::*;

	localparam logic [1:0] REQ_NONE    = 2'd3;
	localparam logic [7:0] REG_HOLE    = 8'hFF;
	localparam int         RandomBeats = 1250;
	localparam int         DrainEvery  = 250;
	localparam int         SettleCycles = 30;
	localparam int         CycleLimit  = 500000;

	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [1:0]  req_type = REQ_READ;
	logic [9:0]  byte_offset = 10'd0;
	logic [1:0]  access_size = SZ_WORD;
	logic [31:0] write_data = 32'd0;
	logic [4:0]  source_number = 5'd0;
	logic        source_level = 1'b0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic [31:0] read_data;
	logic        bus_error;
	logic        fiq_line;
	logic        irq_line;

	int          mismatches;
	int          outstanding;
	int          cycles = 0;
	int          sent = 0;
	int          burst_left = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_left = 0;
	int          stall_tick = 0;

	vectored_interrupt_controller_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_type(req_type),
		.byte_offset(byte_offset),
		.access_size(access_size),
		.write_data(write_data),
		.source_number(source_number),
		.source_level(source_level),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.read_data(read_data),
		.bus_error(bus_error),
		.fiq_line(fiq_line),
		.irq_line(irq_line)
	);

	vic_response_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_type(req_type),
		.byte_offset(byte_offset),
		.access_size(access_size),
		.write_data(write_data),
		.source_number(source_number),
		.source_level(source_level),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.read_data(read_data),
		.bus_error(bus_error),
		.fiq_line(fiq_line),
		.irq_line(irq_line),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver back-pressure: none, light, heavy or periodic, the mode picked at random
	always @(negedge clk) begin
		stall_tick++;
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(16, 128);
		end else
			stall_left <= stall_left - 1;
		case (stall_mode)
			STALL_NONE:  rsp_stall <= 1'b0;
			STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
			default:     rsp_stall <= (stall_tick % 5) < 2;
		endcase
	end

	// one beat on the request channel, bursts separated by random gaps
	task automatic issue(input logic [1:0] kind, input logic [9:0] off, input logic [1:0] size,
			input logic [31:0] data, input logic [4:0] src, input logic lvl);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req_valid <= 1'b1;
		req_type <= kind;
		byte_offset <= off;
		access_size <= size;
		write_data <= data;
		source_number <= src;
		source_level <= lvl;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic bus_write(input logic [7:0] word, input logic [31:0] data,
			input logic [1:0] size);
		issue(REQ_WRITE, {word, 2'b00}, size, data, 5'($urandom), 1'($urandom));
	endtask

	task automatic bus_read(input logic [7:0] word, input logic [1:0] size);
		issue(REQ_READ, {word, 2'b00}, size, $urandom, 5'($urandom), 1'($urandom));
	endtask

	task automatic set_line(input logic [4:0] src, input logic lvl);
		issue(REQ_LINE, 10'($urandom), 2'($urandom), $urandom, src, lvl);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		wait (outstanding == 0);
		@(negedge clk);
		burst_left = 0;
	endtask

	// low sources most of the time so they meet the slot controls
	function automatic logic [4:0] pick_source();
		return ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 7)) : 5'($urandom_range(0, 31));
	endfunction

	function automatic logic [31:0] sparse_mask();
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return (32'd1 << pick_source()) | (32'd1 << pick_source());
	endfunction

	function automatic logic [1:0] legal_size();
		if ($urandom_range(0, 1) == 0)
			return SZ_WORD;
		return 2'($urandom_range(SZ_BYTE, SZ_WORD));
	endfunction

	initial begin
		int          target;
		int          next_drain;
		int          choice;
		logic [4:0]  src;
		logic [7:0]  word;
		logic [31:0] data;

		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		bus_write(VEC_BASE_W, 32'hDEAD_BEEF, SZ_WORD);
		bus_write(VEC_BASE_W + 8'd15, 32'hFFFF_FFFF, SZ_WORD);
		bus_write(CTL_BASE_W, 32'h0000_0023, SZ_WORD);
		bus_write(CTL_BASE_W + 8'd15, 32'hFFFF_FF3F, SZ_BYTE);
		bus_write(REG_DEFV, 32'hABCD_1234, SZ_HALF);
		bus_write(REG_VECT, 32'd0, SZ_WORD);
		bus_write(REG_EN_SET, 32'hFFFF_FFFF, SZ_WORD);
		set_line(5'd3, 1'b1);
		bus_read(REG_VECT, SZ_BYTE);
		bus_read(REG_IRQ_STATUS, SZ_WORD);
		bus_write(REG_VECT, 32'd0, SZ_WORD);
		set_line(5'd3, 1'b0);
		bus_write(REG_VECT, 32'd0, SZ_WORD);
		set_line(5'd17, 1'b1);
		bus_write(REG_SELECT, 32'h0002_0000, SZ_WORD);
		bus_read(REG_FIQ_STATUS, SZ_WORD);
		bus_write(REG_VECT, 32'd0, SZ_WORD);
		bus_write(REG_SOFT_SET, 32'h8000_0000, SZ_WORD);
		bus_read(REG_RAW, SZ_HALF);
		bus_write(REG_IRQ_STATUS, 32'hFFFF_FFFF, SZ_WORD);
		issue(REQ_WRITE, 10'h3FF, SZ_WORD, 32'h1234_5678, 5'd0, 1'b0);
		bus_read(REG_SELECT, SZ_BAD);
		bus_read(REG_HOLE, SZ_WORD);
		issue(REQ_NONE, 10'h0C0, SZ_WORD, 32'hFFFF_FFFF, 5'd31, 1'b1);
		bus_write(REG_EN_CLR, 32'hFFFF_FFFF, SZ_WORD);
		bus_write(REG_SOFT_CLR, 32'hFFFF_FFFF, SZ_WORD);
		drain_results();

		target = sent + RandomBeats;
		next_drain = sent + DrainEvery;
		while (sent < target) begin
			choice = $urandom_range(0, 99);
			if (choice < 10) begin
				// interrupt service: raise, look, maybe drop, acknowledge
				src = pick_source();
				set_line(src, 1'b1);
				bus_read(REG_IRQ_STATUS, SZ_WORD);
				bus_read(REG_VECT, legal_size());
				if ($urandom_range(0, 1) == 0)
					set_line(src, 1'b0);
				bus_write(REG_VECT, $urandom, legal_size());
			end else if (choice < 30)
				set_line(pick_source(), 1'($urandom));
			else if (choice < 37)
				bus_write(REG_VECT, $urandom, legal_size());
			else if (choice < 47) begin
				case ($urandom_range(0, 11))
					0:  word = REG_IRQ_STATUS;
					1:  word = REG_FIQ_STATUS;
					2:  word = REG_RAW;
					3:  word = REG_SELECT;
					4:  word = REG_EN_SET;
					5:  word = REG_EN_CLR;
					6:  word = REG_SOFT_SET;
					7:  word = REG_SOFT_CLR;
					8:  word = REG_VECT;
					9:  word = REG_DEFV;
					10: word = VEC_BASE_W + 8'($urandom_range(0, DefNumSlots - 1));
					default: word = CTL_BASE_W + 8'($urandom_range(0, DefNumSlots - 1));
				endcase
				bus_read(word, legal_size());
			end else if (choice < 54)
				bus_write(REG_EN_SET, sparse_mask(), legal_size());
			else if (choice < 58)
				bus_write(REG_EN_CLR, sparse_mask(), legal_size());
			else if (choice < 63)
				bus_write(REG_SOFT_SET, sparse_mask(), legal_size());
			else if (choice < 68)
				bus_write(REG_SOFT_CLR, sparse_mask(), legal_size());
			else if (choice < 72)
				bus_write(REG_SELECT, sparse_mask(), legal_size());
			else if (choice < 79) begin
				data = $urandom;
				data[CtrlEnableBit] = ($urandom_range(0, 3) != 0);
				if ($urandom_range(0, 3) != 0)
					data[CtrlSrcMsb:3] = 2'b00;
				bus_write(CTL_BASE_W + 8'($urandom_range(0, DefNumSlots - 1)), data, legal_size());
			end else if (choice < 85)
				bus_write(VEC_BASE_W + 8'($urandom_range(0, DefNumSlots - 1)), $urandom,
					legal_size());
			else if (choice < 88)
				bus_write(REG_DEFV, $urandom, legal_size());
			else
				issue(2'($urandom), 10'($urandom), 2'($urandom), $urandom, 5'($urandom),
					1'($urandom));
			if (sent >= next_drain) begin
				drain_results();
				next_drain = sent + DrainEvery;
			end
		end

		req_valid <= 1'b0;
		wait (outstanding == 0);
		repeat (SettleCycles) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
